### sv/kcc_pkg.sv
`timescale 1ns / 1ps

package kcc_pkg;

   // counter and register widths
   localparam int COUNT_WIDTH = 16;
   localparam int CSR_WIDTH   = 16;
   localparam int CMP_WIDTH   = (COUNT_WIDTH > CSR_WIDTH) ? COUNT_WIDTH : CSR_WIDTH;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // register indexes
   typedef enum logic [1:0] {
      CSR_LONG_HOLD = 2'd0,
      CSR_GAP_MIN   = 2'd1,
      CSR_GAP_MAX   = 2'd2
   } csr_index_type;

   // event codes
   typedef enum logic [1:0] {
      EVENT_NONE   = 2'd0,
      EVENT_SINGLE = 2'd1,
      EVENT_DOUBLE = 2'd2,
      EVENT_LONG   = 2'd3
   } click_event_type;

   // threshold set seen by the classifier
   typedef struct packed {
      logic [CSR_WIDTH-1:0] long_hold_ticks;
      logic [CSR_WIDTH-1:0] gap_min_ticks;
      logic [CSR_WIDTH-1:0] gap_max_ticks;
   } thresholds_type;

   // saturating increment
   function automatic logic [COUNT_WIDTH-1:0] count_inc(input logic [COUNT_WIDTH-1:0] v);
      count_inc = (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_WIDTH'(1);
   endfunction

endpackage

### sv/key_click_classifier.sv
`timescale 1ns / 1ps

// key click classifier
// req channel: one sampled key level (req_key_down) per transfer, one tick each.
// rsp channel: one click_event per tick, in tick order: 0 none, 1 single,
//   2 double, 3 long.
// csr port: csr_wr_en with csr_index 0 long hold, 1 gap min, 2 gap max;
//   other indexes are ignored. write only while no tick is in flight.
// path: a taken tick reaches rsp_valid as an event through two register
//   stages (input register, result register).
// throughput: one tick per cycle unless stalled; the classifier is a single
//   stage of compare and increment logic between the two registers.
// stall: while rsp_stall holds a waiting result, the result register and the
//   tracker state freeze; one more tick can sit in the input register, after
//   which req_stall goes high.
// reset: both stages empty, tracker state cleared, thresholds back to
//   50, 5 and 30 ticks.

module key_click_classifier (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic                           req_key_down,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [1:0]                     rsp_click_event,
   input  logic                           csr_wr_en,
   input  logic [1:0]                     csr_index,
   input  logic [kcc_pkg::CSR_WIDTH-1:0]  csr_wdata
);

   kcc_pkg::thresholds_type   thresholds;
   kcc_pkg::click_event_type  core_event;

   logic       in_valid_ff;
   logic       in_key_ff;
   logic       out_valid_ff;
   logic [1:0] out_event_ff;
   logic       out_free;
   logic       advance;
   logic       req_take;

   // pipeline control
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   kcc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .thresholds (thresholds)
   );

   kcc_core u_core (
      .clock       (clock),
      .reset       (reset),
      .tick_en     (advance),
      .key_down    (in_key_ff),
      .thresholds  (thresholds),
      .click_event (core_event)
   );

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_key_ff <= req_key_down;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_event_ff <= core_event;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_click_event = out_event_ff;

endmodule

### sv/kcc_csr.sv
`timescale 1ns / 1ps

module kcc_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_wr_en,
   input  logic [1:0]                           csr_index,
   input  logic [kcc_pkg::CSR_WIDTH-1:0]        csr_wdata,
   output kcc_pkg::thresholds_type              thresholds
);

   kcc_pkg::thresholds_type thr_ff;

   // threshold registers, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff.long_hold_ticks <= kcc_pkg::CSR_WIDTH'(50);
         thr_ff.gap_min_ticks   <= kcc_pkg::CSR_WIDTH'(5);
         thr_ff.gap_max_ticks   <= kcc_pkg::CSR_WIDTH'(30);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            kcc_pkg::CSR_LONG_HOLD: thr_ff.long_hold_ticks <= csr_wdata;
            kcc_pkg::CSR_GAP_MIN:   thr_ff.gap_min_ticks   <= csr_wdata;
            kcc_pkg::CSR_GAP_MAX:   thr_ff.gap_max_ticks   <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign thresholds = thr_ff;

endmodule

### sv/kcc_core.sv
`timescale 1ns / 1ps

module kcc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        tick_en,
   input  logic                        key_down,
   input  kcc_pkg::thresholds_type     thresholds,
   output kcc_pkg::click_event_type    click_event
);

   logic                              lockout_ff, lockout_in;
   logic                              press_seen_ff, press_seen_in;
   logic [kcc_pkg::COUNT_WIDTH-1:0]   hold_ticks_ff, hold_ticks_in;
   logic [kcc_pkg::COUNT_WIDTH-1:0]   release_ticks_ff, release_ticks_in;
   logic [kcc_pkg::CMP_WIDTH-1:0]     hold_cmp, rel_cmp, long_cmp, gmin_cmp, gmax_cmp;
   logic [kcc_pkg::COUNT_WIDTH-1:0]   hold_mid, rel_mid;
   logic                              lock_mid, seen_mid;

   // classification for one tick
   always_comb begin
      lock_mid    = lockout_ff;
      seen_mid    = press_seen_ff;
      hold_mid    = hold_ticks_ff;
      rel_mid     = release_ticks_ff;
      click_event = kcc_pkg::EVENT_NONE;

      // lockout clears counts, released once the key is up
      if (lockout_ff) begin
         seen_mid = 1'b0;
         hold_mid = '0;
         rel_mid  = '0;
         if (!key_down) begin
            lock_mid = 1'b0;
         end
      end

      // hold counting
      if (key_down && !lock_mid) begin
         seen_mid = 1'b1;
         hold_mid = kcc_pkg::count_inc(hold_mid);
      end

      hold_cmp = kcc_pkg::CMP_WIDTH'(hold_mid);
      long_cmp = kcc_pkg::CMP_WIDTH'(thresholds.long_hold_ticks);
      gmin_cmp = kcc_pkg::CMP_WIDTH'(thresholds.gap_min_ticks);
      gmax_cmp = kcc_pkg::CMP_WIDTH'(thresholds.gap_max_ticks);

      // release counting happens only when no long click is due
      if (!(hold_cmp > long_cmp) && seen_mid && !key_down) begin
         rel_mid = kcc_pkg::count_inc(rel_mid);
      end
      rel_cmp = kcc_pkg::CMP_WIDTH'(rel_mid);

      // event decision
      if (hold_cmp > long_cmp) begin
         lock_mid    = 1'b1;
         click_event = kcc_pkg::EVENT_LONG;
      end else if (seen_mid && rel_cmp > gmin_cmp && rel_cmp < gmax_cmp) begin
         if (key_down) begin
            lock_mid    = 1'b1;
            click_event = kcc_pkg::EVENT_DOUBLE;
         end
      end else if (seen_mid && rel_cmp > gmax_cmp) begin
         lock_mid    = 1'b1;
         click_event = kcc_pkg::EVENT_SINGLE;
      end

      lockout_in       = lock_mid;
      press_seen_in    = seen_mid;
      hold_ticks_in    = hold_mid;
      release_ticks_in = rel_mid;
   end

   // tracker state
   always_ff @(posedge clock) begin
      if (reset) begin
         lockout_ff       <= 1'b0;
         press_seen_ff    <= 1'b0;
         hold_ticks_ff    <= '0;
         release_ticks_ff <= '0;
      end else if (tick_en) begin
         lockout_ff       <= lockout_in;
         press_seen_ff    <= press_seen_in;
         hold_ticks_ff    <= hold_ticks_in;
         release_ticks_ff <= release_ticks_in;
      end
   end

endmodule
